@@ sv/time_window_moving_average_core_macros.svh @@
// assertion shorthands for the core rtl file
`ifndef TIME_WINDOW_MOVING_AVERAGE_CORE_MACROS_SVH
`define TIME_WINDOW_MOVING_AVERAGE_CORE_MACROS_SVH

// consequent checked in the same cycle
`define TWMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TWMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/twma_pkg.sv @@
package twma_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int CNT_W_DEF     = $clog2(DEPTH_DEF + 1);
    localparam int TIME_W        = 32;
    localparam int SAMPLE_W      = 32;
    localparam int SUM_W         = 40;
    localparam int AVG_W         = 32;
    localparam int COUNT_OUT_W   = 9;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int DIV_STEP_W    = $clog2(SUM_W);

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;

    // register index taken from the word address bit
    localparam logic REG_WINDOW_MS = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0]          now_ms;
        logic                       carries_value;
        logic signed [SAMPLE_W-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]     window_sum;
        logic signed [AVG_W-1:0]     window_average;
        logic [COUNT_OUT_W-1:0]      sample_count;
        logic                        dropped;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [SAMPLE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                     done;
        logic signed [AVG_W-1:0]  quotient;
    } div_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP,
        ST_APPEND,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_DIV,
        ST_RESULT
    } state_t;

endpackage

@@ sv/twma_div.sv @@
module twma_div #(
    parameter int CNT_W = twma_pkg::CNT_W_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [twma_pkg::SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]                  divisor,
    output twma_pkg::div_res_t                res
);
    import twma_pkg::*;

    localparam logic [SUM_W-1:0] POS_LIMIT = 40'h00_7FFF_FFFF;
    localparam logic [SUM_W-1:0] NEG_LIMIT = 40'h00_8000_0000;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      dvs_reg, dvs_next;

    logic [CNT_W:0]        rem_shift;
    logic                  fits;
    logic [SUM_W-1:0]      quo_neg;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            // work on the magnitude, fix the sign at the end
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(SUM_W - 1);
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? CNT_W'(rem_shift - {1'b0, dvs_reg}) : CNT_W'(rem_shift);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - DIV_STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    // signed result with saturation to 32 bits
    assign quo_neg = SUM_W'(0) - quo_reg;

    always_comb
    begin
        res.done = done_reg;
        if (neg_reg)
        begin
            if (quo_reg > NEG_LIMIT)
                res.quotient = AVG_W'(NEG_LIMIT);
            else
                res.quotient = quo_neg[AVG_W-1:0];
        end
        else
        begin
            if (quo_reg > POS_LIMIT)
                res.quotient = AVG_W'(POS_LIMIT);
            else
                res.quotient = quo_reg[AVG_W-1:0];
        end
    end

endmodule

@@ sv/time_window_moving_average_core.sv @@
// item path: drop the oldest entry when full, append the sample, evict expired entries, divide, emit
// a tick without a sample skips the drop and append, and skips the divide when it leaves the window empty
// throughput: one item at a time, set by the 40-step bit-serial divider and the eviction walk
// eviction reads one stored entry per cycle from the sample memory read port
// reset: window_ms back to 1000, store empty, running sum zero, no result pending
// sample memory contents are not cleared, only entries written since reset are read
`include "time_window_moving_average_core_macros.svh"

module time_window_moving_average_core #(
    parameter int DEPTH = twma_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  twma_pkg::item_t                    item,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output twma_pkg::result_t                  result,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [twma_pkg::ADDR_W-1:0]        paddr,
    input  logic [twma_pkg::DATA_W-1:0]        pwdata,
    output logic [twma_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import twma_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // fsm
    state_t state_reg, state_next;

    // queue bookkeeping
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [TIME_W-1:0]       window_reg;

    // current item word
    logic [TIME_W-1:0]          now_reg, now_next;
    logic                       carries_reg, carries_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       dropped_reg, dropped_next;
    logic signed [AVG_W-1:0]    avg_reg, avg_next;

    // output stage
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // sample memory, one write port at the tail, one read port at the head
    entry_t           mem [DEPTH];
    entry_t           rd_data_reg;
    logic             mem_we;
    logic [PTR_W-1:0] rd_addr;

    logic                    item_take;
    logic                    cfg_write;
    logic                    out_free;
    logic [PTR_W-1:0]        head_inc;
    logic [PTR_W-1:0]        tail_inc;
    logic [TIME_W-1:0]       age;
    logic                    expired;
    logic signed [SUM_W-1:0] head_value;
    logic signed [SUM_W-1:0] new_value;
    logic                    div_start;
    div_res_t                div_res;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // register port: single window register, word index from the address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WINDOW_MS) ? window_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WINDOW_RESET;
        else if (cfg_write && paddr[2] == REG_WINDOW_MS)
            window_reg <= pwdata;
    end

    // ring pointer steps
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    // head entry as read back in the cycle after its address
    assign age        = now_reg - rd_data_reg.stamp;
    assign expired    = age > window_reg;
    assign head_value = SUM_W'(signed'(rd_data_reg.value));
    assign new_value  = SUM_W'(sample_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (!item.carries_value)
                        state_next = ST_EVICT_RD;
                    else if (count_reg == CNT_W'(DEPTH))
                        state_next = ST_DROP_RD;
                    else
                        state_next = ST_APPEND;
                end
            end
            ST_DROP_RD:
                state_next = ST_DROP;
            ST_DROP:
                state_next = ST_APPEND;
            ST_APPEND:
                state_next = ST_EVICT_RD;
            ST_EVICT_RD:
                state_next = (count_reg == '0) ? ST_RESULT : ST_EVICT_CHK;
            ST_EVICT_CHK:
            begin
                if (!expired)
                    state_next = ST_DIV;
                else if (count_reg == CNT_W'(1))
                    state_next = ST_RESULT;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        now_next          = now_reg;
        carries_next      = carries_reg;
        sample_next       = sample_reg;
        dropped_next      = dropped_reg;
        avg_next          = avg_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        mem_we            = 1'b0;
        div_start         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    now_next     = item.now_ms;
                    carries_next = item.carries_value;
                    sample_next  = item.sample_value;
                    dropped_next = 1'b0;
                    avg_next     = '0;
                end
            end
            ST_DROP_RD:
            begin
            end
            ST_DROP:
            begin
                // store full: oldest goes before the append
                sum_next     = sum_reg - head_value;
                head_next    = head_inc;
                count_next   = count_reg - CNT_W'(1);
                dropped_next = 1'b1;
            end
            ST_APPEND:
            begin
                mem_we     = 1'b1;
                tail_next  = tail_inc;
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg + new_value;
            end
            ST_EVICT_RD:
            begin
            end
            ST_EVICT_CHK:
            begin
                if (expired)
                begin
                    sum_next   = sum_reg - head_value;
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                    avg_next = div_res.quotient;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    result_valid_next          = 1'b1;
                    result_next.window_sum     = sum_reg;
                    result_next.window_average = avg_reg;
                    result_next.sample_count   = COUNT_OUT_W'(count_reg);
                    result_next.dropped        = dropped_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // read address follows the head as it will be next cycle
    assign rd_addr = head_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_reg] <= '{stamp: now_reg, value: sample_reg};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        carries_reg <= carries_next;
        sample_reg  <= sample_next;
        dropped_reg <= dropped_next;
        avg_reg     <= avg_next;
        result_reg  <= result_next;
    end

    // serial divide of the running sum by the entry count
    twma_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .res      (div_res)
    );

    `TWMA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `TWMA_ASSERT_NOW(a_empty_ptrs, state_reg == ST_IDLE && count_reg == '0, head_reg == tail_reg, "empty store with pointers apart")
    `TWMA_ASSERT_NEXT(a_busy_after_take, item_take, state_reg != ST_IDLE, "item taken but fsm idle")
    `TWMA_ASSERT_NOW(a_div_nonempty, div_start, count_reg != '0, "divide started on empty store")
    `TWMA_ASSERT_NOW(a_drop_full, state_reg == ST_DROP, count_reg == CNT_W'(DEPTH) && carries_reg, "drop without full store")

endmodule

@@ tb/sv/time_window_moving_average_core_tb.sv @@
module time_window_moving_average_core_tb;
    import twma_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    // longest eviction walk plus a full-store drop plus divider, with margin
    localparam int SETTLE_CYCLES = 400;
    localparam logic [ADDR_W-1:0] WINDOW_MS_ADDR = {REG_WINDOW_MS, 2'b00};
    localparam result_t NO_RESULT = '0;

    typedef struct {
        item_t   word;
        bit      typed;
        result_t want;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // window predictor state: stored samples in arrival order and their sum
    entry_t                  held[$];
    logic signed [SUM_W-1:0] window_total;
    logic [TIME_W-1:0]       window_len;

    result_t due_results[$];
    row_t    plan[$];
    int      fail_count;
    int      cycle_count;
    // 0 means no idling, otherwise one chance in idle_odds per item word for a gap and per cycle for a result stall
    int      idle_odds;
    int      stall_left;
    logic [TIME_W-1:0] ms_now;

    time_window_moving_average_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // drop when full, append, evict stale entries, then average
    task automatic predict_window(input item_t w, output result_t r);
        logic [TIME_W-1:0] age;
        longint            quot;
        entry_t            fresh;
        r = NO_RESULT;
        if (w.carries_value)
        begin
            if (held.size() >= DEPTH_DEF)
            begin
                window_total = window_total - $signed(held[0].value);
                held.delete(0);
                r.dropped = 1'b1;
            end
            fresh.stamp = w.now_ms;
            fresh.value = w.sample_value;
            held.insert(held.size(), fresh);
            window_total = window_total + $signed(w.sample_value);
        end
        while (held.size() > 0)
        begin
            age = w.now_ms - held[0].stamp;
            if (age <= window_len)
                break;
            window_total = window_total - $signed(held[0].value);
            held.delete(0);
        end
        quot = 0;
        if (held.size() > 0)
        begin
            quot = longint'(window_total) / longint'(held.size());
            if (quot > 64'sd2147483647)
                quot = 64'sd2147483647;
            if (quot < -64'sd2147483648)
                quot = -64'sd2147483648;
        end
        r.window_sum     = window_total;
        r.window_average = quot[AVG_W-1:0];
        r.sample_count   = COUNT_OUT_W'(held.size());
    endtask

    // hold the word until accepted, then leave valid high unless a gap follows
    task automatic send_word(input item_t w, input bit typed, input result_t want, input int gap);
        result_t r;
        item       <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict_window(w, r);
        due_results.insert(due_results.size(), typed ? want : r);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= WINDOW_MS_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the window, mirror it, and read it back
    task automatic set_window(input logic [TIME_W-1:0] len);
        logic [DATA_W-1:0] rd;
        apb_access(1'b1, len, rd);
        window_len = len;
        @(posedge clk);
        apb_access(1'b0, '0, rd);
        if (rd !== len)
        begin
            $error("window_ms: expected %0d, got %0d", len, rd);
            fail_count++;
        end
        @(posedge clk);
    endtask

    task automatic add_row(input logic [TIME_W-1:0] at_ms, input logic has_value,
                           input logic [SAMPLE_W-1:0] value, input bit typed,
                           input result_t want);
        row_t row;
        row.word  = '{now_ms: at_ms, carries_value: has_value, sample_value: value};
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    function automatic int pick_gap;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            return $urandom_range(1, 7);
        return 0;
    endfunction

    // time moves on in small steps with occasional jumps anywhere
    task automatic run_phase(input int n, input int step_max, input int pct_value,
                             input int pct_jump);
        item_t w;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < pct_jump)
                ms_now = $urandom;
            else
                ms_now = ms_now + $urandom_range(0, step_max);
            w.now_ms        = ms_now;
            w.carries_value = ($urandom_range(0, 99) < pct_value);
            case ($urandom_range(0, 9))
                0:       w.sample_value = 32'h7FFF_FFFF;
                1:       w.sample_value = 32'h8000_0000;
                2:       w.sample_value = $urandom_range(0, 255);
                3:       w.sample_value = -$signed({1'b0, 8'($urandom)});
                default: w.sample_value = $urandom;
            endcase
            send_word(w, 1'b0, NO_RESULT, pick_gap());
        end
    endtask

    // result side: check against the oldest expectation, stall in bursts
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result word with no expectation");
                fail_count++;
            end
            else
            begin
                want = due_results[0];
                due_results.delete(0);
                if (result.window_sum !== want.window_sum)
                begin
                    $error("window_sum: expected %0d, got %0d",
                           want.window_sum, result.window_sum);
                    fail_count++;
                end
                if (result.window_average !== want.window_average)
                begin
                    $error("window_average: expected %0d, got %0d",
                           want.window_average, result.window_average);
                    fail_count++;
                end
                if (result.sample_count !== want.sample_count)
                begin
                    $error("sample_count: expected %0d, got %0d",
                           want.sample_count, result.sample_count);
                    fail_count++;
                end
                if (result.dropped !== want.dropped)
                begin
                    $error("dropped: expected %0d, got %0d", want.dropped, result.dropped);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            stall_left = $urandom_range(1, 7);
        result_stall <= (stall_left != 0);
    end

    initial
    begin
        fail_count   = 0;
        cycle_count  = 0;
        stall_left   = 0;
        idle_odds    = 4;
        held.delete();
        window_total = '0;
        window_len   = WINDOW_RESET;
        ms_now       = '0;

        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        result_stall <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset window of 1000 ms
        // tick on an empty store, sample ignored
        add_row(32'd0, 1'b0, 32'hDEAD_BEEF, 1'b1, NO_RESULT);
        // largest positive sample
        add_row(32'd0, 1'b1, 32'h7FFF_FFFF, 1'b1,
                '{window_sum: 40'h00_7FFF_FFFF, window_average: 32'h7FFF_FFFF,
                  sample_count: 9'd1, dropped: 1'b0});
        // most negative sample, sum -1 averages to zero
        add_row(32'd1, 1'b1, 32'h8000_0000, 1'b1,
                '{window_sum: 40'hFF_FFFF_FFFF, window_average: 32'h0,
                  sample_count: 9'd2, dropped: 1'b0});
        // age exactly at the window, then one past it
        add_row(32'd1000, 1'b0, 32'h0, 1'b0, NO_RESULT);
        add_row(32'd1001, 1'b0, 32'h0, 1'b0, NO_RESULT);
        // everything aged out, window empty
        add_row(32'd1002, 1'b0, 32'h0, 1'b1, NO_RESULT);
        // time going back makes the older stamp look ancient
        add_row(32'd5000, 1'b1, 32'h0001_0000, 1'b0, NO_RESULT);
        add_row(32'd4000, 1'b1, 32'h0002_0000, 1'b0, NO_RESULT);
        // time wrapping past 2^32
        add_row(32'hFFFF_FF00, 1'b1, 32'h1, 1'b0, NO_RESULT);
        add_row(32'h0000_0010, 1'b1, 32'h3, 1'b0, NO_RESULT);
        // negative sums truncate toward zero
        add_row(32'h0000_0020, 1'b1, 32'hFFFF_FFFB, 1'b0, NO_RESULT);
        add_row(32'h0000_0020, 1'b1, 32'hFFFF_FFFB, 1'b0, NO_RESULT);
        add_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, NO_RESULT);
        add_row(32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, NO_RESULT);
        add_row(32'h8000_0000, 1'b1, 32'h5555_5555, 1'b0, NO_RESULT);
        add_row(32'h8000_0001, 1'b1, 32'hAAAA_AAAA, 1'b0, NO_RESULT);
        add_row(32'h8000_0001, 1'b0, 32'h1234_5678, 1'b0, NO_RESULT);
        foreach (plan[i])
            send_word(plan[i].word, plan[i].typed, plan[i].want, pick_gap());
        ms_now = 32'h8000_0001;
        drain();

        // zero window keeps only samples of the current millisecond
        set_window(32'd0);
        run_phase(150, 2, 80, 3);
        drain();

        // widest window never ages anything out, so the store fills and drops
        idle_odds = 3;
        set_window(32'hFFFF_FFFF);
        run_phase(350, 100, 90, 5);
        drain();

        // dense samples in a 1000 ms window: full store and evictions mixed
        idle_odds = 8;
        set_window(32'd1000);
        run_phase(300, 4, 85, 2);
        drain();

        idle_odds = 0;
        set_window($urandom_range(1, 5000));
        run_phase(200, 50, 70, 3);
        drain();

        idle_odds = 5;
        set_window(32'd1);
        run_phase(150, 2, 60, 2);
        drain();

        // closing stretch at full rate
        idle_odds = 0;
        set_window(32'd1000);
        run_phase(100, 10, 80, 2);
        item_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", due_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
